@@ design/cbip_pkg.sv @@
// cbip_pkg: shared types and constants for the custom base integer parser
// holds item structs, kind and phase codes, character codes and sizes
// no dependencies
package cbip_pkg;

  localparam int MAX_SYMBOLS_DEF = 128;
  localparam int VALUE_W         = 32;
  localparam int CHAR_W          = 8;
  localparam int CODE_W          = 7;
  localparam int NUM_CODES       = 1 << CODE_W;
  localparam int Q_DEPTH         = 2;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] SYM_LO   = 8'd33;
  localparam logic [CHAR_W-1:0] SYM_HI   = 8'd126;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_CHAR   = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    PH_SPACE = 4'b0001,
    PH_SIGN  = 4'b0010,
    PH_DIGIT = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] character;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      base_valid;
  } out_item_t;

  // classified item as it travels from front to back
  typedef struct packed {
    kind_t             kind;
    logic [CODE_W-1:0] code;
    logic              low;
    logic              sym_legal;
    logic              is_space;
    logic              is_plus;
    logic              is_minus;
  } op_t;

endpackage

@@ design/cbip_ram.sv @@
// cbip_ram: generic single write port, single read port ram
// read data registered, no reset on contents
// no dependencies
module cbip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/cbip_front.sv @@
// cbip_front: input acceptance and character classification
// depends on cbip_pkg
module cbip_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  cbip_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               push,
  output cbip_pkg::op_t      push_data
);
  import cbip_pkg::*;

  logic [CHAR_W-1:0] c;

  assign c        = in_data.character;
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_data.kind      = in_data.kind;
    push_data.code      = c[CODE_W-1:0];
    push_data.low       = !c[CHAR_W-1];
    push_data.is_plus   = (c == CH_PLUS);
    push_data.is_minus  = (c == CH_MINUS);
    push_data.is_space  = (c >= CH_TAB && c <= CH_CR) || (c == CH_SPACE);
    push_data.sym_legal = (c >= SYM_LO) && (c <= SYM_HI) && (c != CH_PLUS)
                          && (c != CH_MINUS);
  end

endmodule

@@ design/cbip_queue.sv @@
// cbip_queue: short fifo of classified items between front and back
// depends on cbip_pkg
module cbip_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cbip_pkg::op_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output cbip_pkg::op_t head_data
);
  import cbip_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  op_t              slot_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ design/cbip_back.sv @@
// cbip_back: alphabet upkeep, parse state machine, multiply-accumulate, result register
// depends on cbip_pkg and cbip_ram
module cbip_back #(
  parameter int MAX_SYMBOLS = cbip_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  cbip_pkg::op_t       q_head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output cbip_pkg::out_item_t out_data
);
  import cbip_pkg::*;

  localparam int DIG_W  = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int SIZE_W = $clog2(MAX_SYMBOLS + 1);
  localparam int PROD_W = VALUE_W + SIZE_W;

  logic                 ex_valid_r, ex_valid_nxt;
  op_t                  ex_op_r;
  logic                 fwd_hit_r, fwd_hit_nxt;
  logic [DIG_W-1:0]     fwd_data_r;
  logic [NUM_CODES-1:0] in_alpha_r, in_alpha_nxt;
  logic [SIZE_W-1:0]    size_r, size_nxt;
  logic                 bad_r, bad_nxt;
  phase_t               phase_r, phase_nxt;
  logic                 neg_r, neg_nxt;
  logic [VALUE_W-1:0]   acc_r, acc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;
  logic                 out_load;

  logic                 ex_done;
  logic                 hit;
  logic [DIG_W-1:0]     ram_rdata;
  logic [DIG_W-1:0]     digit;
  logic [PROD_W-1:0]    prod;
  logic [VALUE_W-1:0]   mac;
  logic                 we;
  logic                 base_ok;
  phase_t               ph_v;

  cbip_ram #(
    .WIDTH(DIG_W),
    .DEPTH(NUM_CODES)
  ) u_digit_ram (
    .clk  (clk),
    .we   (we),
    .waddr(ex_op_r.code),
    .wdata(size_r[DIG_W-1:0]),
    .re   (pop),
    .raddr(q_head.code),
    .rdata(ram_rdata)
  );

  assign ex_done  = ex_valid_r && !(ex_op_r.kind == KIND_END && out_valid_r && out_stall);
  assign pop      = q_valid && (!ex_valid_r || ex_done);
  assign hit      = ex_op_r.low && in_alpha_r[ex_op_r.code];
  assign digit    = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign prod     = PROD_W'(acc_r) * PROD_W'(size_r);
  assign mac      = prod[VALUE_W-1:0] + VALUE_W'(digit);
  assign base_ok  = !bad_r && (size_r >= SIZE_W'(2));

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    in_alpha_nxt  = in_alpha_r;
    size_nxt      = size_r;
    bad_nxt       = bad_r;
    phase_nxt     = phase_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    we            = 1'b0;
    ph_v          = phase_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (ex_done) begin
      unique case (ex_op_r.kind)
        KIND_CLEAR: begin
          in_alpha_nxt = '0;
          size_nxt     = '0;
          bad_nxt      = 1'b0;
        end
        KIND_APPEND: begin
          if (!ex_op_r.sym_legal || hit || size_r >= SIZE_W'(MAX_SYMBOLS)) begin
            bad_nxt = 1'b1;
          end else begin
            we                         = 1'b1;
            in_alpha_nxt[ex_op_r.code] = 1'b1;
            size_nxt                   = size_r + 1'b1;
          end
        end
        KIND_CHAR: begin
          if (ph_v == PH_SPACE && !ex_op_r.is_space) begin
            ph_v = PH_SIGN;
          end
          if (ph_v == PH_SIGN) begin
            if (ex_op_r.is_minus) begin
              neg_nxt = !neg_r;
            end else if (!ex_op_r.is_plus) begin
              ph_v = PH_DIGIT;
            end
          end
          if (ph_v == PH_DIGIT) begin
            if (hit) begin
              acc_nxt = mac;
            end else begin
              ph_v = PH_DONE;
            end
          end
          phase_nxt = ph_v;
        end
        KIND_END: begin
          out_load                = 1'b1;
          out_valid_nxt           = 1'b1;
          out_data_nxt.base_valid = base_ok;
          out_data_nxt.value      = !base_ok ? '0 :
                                    neg_r ? signed'(-acc_r) : signed'(acc_r);
          phase_nxt               = PH_SPACE;
          neg_nxt                 = 1'b0;
          acc_nxt                 = '0;
        end
      endcase
    end
  end

  always_comb begin
    ex_valid_nxt = ex_valid_r;
    if (pop) begin
      ex_valid_nxt = 1'b1;
    end else if (ex_done) begin
      ex_valid_nxt = 1'b0;
    end
    fwd_hit_nxt = we && (ex_op_r.code == q_head.code);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r  <= 1'b0;
      in_alpha_r  <= '0;
      size_r      <= '0;
      bad_r       <= 1'b0;
      phase_r     <= PH_SPACE;
      neg_r       <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ex_valid_r  <= ex_valid_nxt;
      in_alpha_r  <= in_alpha_nxt;
      size_r      <= size_nxt;
      bad_r       <= bad_nxt;
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item payload, same-address write forwarding and result data
  always_ff @(posedge clk) begin
    if (pop) begin
      ex_op_r    <= q_head;
      fwd_hit_r  <= fwd_hit_nxt;
      fwd_data_r <= size_r[DIG_W-1:0];
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

@@ design/custom_base_integer_parser.sv @@
// custom_base_integer_parser: parses character items into signed integers
// over a programmable digit alphabet; top level joining front, queue and back
// depends on cbip_pkg, cbip_front, cbip_queue, cbip_back
//
// input channel: in_valid/in_stall/in_data, one item per cycle unless stalled;
// kind selects clear alphabet, append symbol, string character or end of string
// output channel: out_valid/out_stall/out_data, one item per end of string
// with the wrapped signed value and the alphabet validity flag
// throughput: one input item per clock while in_stall is low, set by the
// multiply-accumulate and digit lookup in the back end
// a result shows on out_valid once its end item has passed the queue register,
// the execute register and the result register
// the digit table is a 128-entry ram with registered read; a symbol appended
// just before a string character is forwarded around it
// reset: empty alphabet, parser at whitespace skipping, queue and result empty,
// in_stall low; the digit ram needs no clearing
// receiver stall: the result holds in its register, the next end item waits
// in execute, the two-entry queue fills and then in_stall rises
module custom_base_integer_parser #(
  parameter int MAX_SYMBOLS = cbip_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cbip_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cbip_pkg::out_item_t out_data
);
  import cbip_pkg::*;

  logic q_full;
  logic push;
  op_t  push_data;
  logic pop;
  logic q_valid;
  op_t  q_head;

  cbip_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_data(push_data)
  );

  cbip_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head_valid(q_valid),
    .head_data (q_head)
  );

  cbip_back #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("queue or result not empty after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.base_valid |-> out_data.value == '0)
    else $error("nonzero value with invalid alphabet");

  a_stall_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("queue filled without an accepted item");

  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("back end took an item from an empty queue");

endmodule
